>>> rtl/core/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, constants and helpers for the ARGB8888 recolour and
// premultiply pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

    // Width of one colour or alpha channel.
    localparam int ChanW = 8;

    // Full-scale channel value (opaque alpha, maximum colour).
    localparam logic [ChanW-1:0] ChanMax = 8'hFF;

    // Configuration port widths.
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 32;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgIdxRecolor = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgIdxPremul  = 8'd1;

    // One input pixel request.
    typedef struct packed {
        logic [ChanW-1:0] in_alpha;
        logic [ChanW-1:0] in_red;
        logic [ChanW-1:0] in_green;
        logic [ChanW-1:0] in_blue;
    } pix_in_t;

    // One result pixel request.
    typedef struct packed {
        logic [ChanW-1:0] out_alpha;
        logic [ChanW-1:0] out_red;
        logic [ChanW-1:0] out_green;
        logic [ChanW-1:0] out_blue;
    } pix_out_t;

    // Per-pixel information that travels alongside the colour channels.
    typedef struct packed {
        logic [ChanW-1:0] alpha;
        logic             opa_zero;
        logic             premul;
    } side_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } adv_t;

    // Exact floor(x / 255) for x up to 255 * 255, by the usual add-and-shift.
    function automatic logic [8:0] div255(input logic [16:0] x);
        logic [16:0] t;
        t = x + {8'd0, x[16:8]} + 17'd1;
        return t[16:8];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/arp_cfg.sv
// ----------------------------------------------------------------------------
// arp_cfg
// Configuration registers: recolour colour with opacity, and the flag that
// marks the source as already premultiplied.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [arp_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [arp_pkg::CfgDataW-1:0]  cfg_data,
    output logic [arp_pkg::CfgDataW-1:0]       recolor,
    output logic                               premul
);

    logic [arp_pkg::CfgDataW-1:0] recolor_reg;
    logic                         premul_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register file; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recolor_reg <= '0;
            premul_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == arp_pkg::CfgIdxRecolor)
            begin
                recolor_reg <= cfg_data;
            end
            else if (cfg_index == arp_pkg::CfgIdxPremul)
            begin
                premul_reg <= cfg_data[0];
            end
        end
    end

    assign recolor = recolor_reg;
    assign premul  = premul_reg;

endmodule

`default_nettype wire

>>> rtl/core/arp_ctrl.sv
// ----------------------------------------------------------------------------
// arp_ctrl
// Pipeline control: valid bits and load enables of the four stages, and the
// per-pixel alpha and mode flags that travel with each request.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [arp_pkg::ChanW-1:0]   alpha_in,
    input  wire logic                        opa_zero,
    input  wire logic                        premul,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output arp_pkg::adv_t                    adv,
    output arp_pkg::side_t                   side2,
    output arp_pkg::side_t                   side3,
    output logic [arp_pkg::ChanW-1:0]        alpha_out
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic mv1, mv2, mv3, mv4;
    logic zero_px;

    arp_pkg::side_t side1_reg, side2_reg, side3_reg;
    logic [arp_pkg::ChanW-1:0] alpha4_reg;

    // A stage moves on when the next one loads; the last when not stalled.
    always_comb
    begin
        mv4     = !out_stall;
        adv.en4 = v3_reg && (!v4_reg || mv4);
        mv3     = adv.en4;
        adv.en3 = v2_reg && (!v3_reg || mv3);
        mv2     = adv.en3;
        adv.en2 = v1_reg && (!v2_reg || mv2);
        mv1     = adv.en2;
        adv.en1 = in_valid && (!v1_reg || mv1);
        in_stall = v1_reg && !mv1;
    end

    // Valid bits: set on load, cleared when the request moves on.
    always_comb
    begin
        v1_next = adv.en1 ? 1'b1 : (mv1 ? 1'b0 : v1_reg);
        v2_next = adv.en2 ? 1'b1 : (mv2 ? 1'b0 : v2_reg);
        v3_next = adv.en3 ? 1'b1 : (mv3 ? 1'b0 : v3_reg);
        v4_next = adv.en4 ? 1'b1 : (mv4 ? 1'b0 : v4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // A transparent pixel clears to zero unless it passes through untouched.
    assign zero_px = (side3_reg.alpha == '0) && !(side3_reg.premul && side3_reg.opa_zero);

    // Sideband registers follow the stage enables.
    always_ff @(posedge clk)
    begin
        if (adv.en1)
        begin
            side1_reg <= '{alpha: alpha_in, opa_zero: opa_zero, premul: premul};
        end
        if (adv.en2)
        begin
            side2_reg <= side1_reg;
        end
        if (adv.en3)
        begin
            side3_reg <= side2_reg;
        end
        if (adv.en4)
        begin
            alpha4_reg <= zero_px ? '0 : side3_reg.alpha;
        end
    end

    assign out_valid = v4_reg;
    assign side2     = side2_reg;
    assign side3     = side3_reg;
    assign alpha_out = alpha4_reg;

endmodule

`default_nettype wire

>>> rtl/core/arp_chan.sv
// ----------------------------------------------------------------------------
// arp_chan
// Datapath of one colour channel: recolour blend and premultiply over four
// register stages, one multiplier level or one add and divide per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_chan (
    input  wire logic                        clk,
    input  wire arp_pkg::adv_t               adv,
    input  wire logic [arp_pkg::ChanW-1:0]   src,
    input  wire logic [arp_pkg::ChanW-1:0]   rc,
    input  wire logic [arp_pkg::ChanW-1:0]   opa,
    input  wire arp_pkg::side_t              side2,
    input  wire arp_pkg::side_t              side3,
    output logic [arp_pkg::ChanW-1:0]        result
);

    localparam int ProdW = 2 * arp_pkg::ChanW;

    // Stage 1: products of source by the remaining weight and recolour by opacity.
    logic [arp_pkg::ChanW-1:0] src1_reg;
    logic [ProdW-1:0]          p1_1_reg, p2_1_reg;
    logic [arp_pkg::ChanW-1:0] mix;

    // Stage 2: blended value and scaled recolour term.
    logic [arp_pkg::ChanW-1:0] src2_reg, c1_2_reg, q2_reg;
    logic [ProdW-1:0]          p1_2_reg;
    logic [ProdW:0]            sum2;
    logic [8:0]                c1_div, q_div;

    // Stage 3: second product by alpha.
    logic [arp_pkg::ChanW-1:0] src3_reg, c1_3_reg;
    logic [ProdW-1:0]          p1_3_reg, m3_reg;
    logic [arp_pkg::ChanW-1:0] mul_x;

    // Stage 4: final division and mode selection.
    logic [ProdW:0]            sum4;
    logic [8:0]                d4;
    logic [arp_pkg::ChanW-1:0] d4_sat;
    logic [arp_pkg::ChanW-1:0] res_next;
    logic [arp_pkg::ChanW-1:0] res_reg;
    logic                      zero_px;
    logic                      opaque;

    assign mix = arp_pkg::ChanMax - opa;

    // First multiplier level.
    always_ff @(posedge clk)
    begin
        if (adv.en1)
        begin
            src1_reg <= src;
            p1_1_reg <= ProdW'(src) * ProdW'(mix);
            p2_1_reg <= ProdW'(rc) * ProdW'(opa);
        end
    end

    // Blend sum and divides by 255.
    assign sum2   = {1'b0, p1_1_reg} + {1'b0, p2_1_reg};
    assign c1_div = arp_pkg::div255(sum2);
    assign q_div  = arp_pkg::div255({1'b0, p2_1_reg});

    always_ff @(posedge clk)
    begin
        if (adv.en2)
        begin
            src2_reg <= src1_reg;
            p1_2_reg <= p1_1_reg;
            c1_2_reg <= c1_div[arp_pkg::ChanW-1:0];
            q2_reg   <= q_div[arp_pkg::ChanW-1:0];
        end
    end

    // Operand for the alpha product depends on the mode.
    always_comb
    begin
        if (side2.opa_zero)
        begin
            mul_x = src2_reg;
        end
        else if (side2.premul)
        begin
            mul_x = q2_reg;
        end
        else
        begin
            mul_x = c1_2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.en3)
        begin
            src3_reg <= src2_reg;
            p1_3_reg <= p1_2_reg;
            c1_3_reg <= c1_2_reg;
            m3_reg   <= ProdW'(mul_x) * ProdW'(side2.alpha);
        end
    end

    // Premultiplied blends add the source term before the last divide.
    assign sum4   = (side3.premul && !side3.opa_zero) ?
                    ({1'b0, p1_3_reg} + {1'b0, m3_reg}) : {1'b0, m3_reg};
    assign d4     = arp_pkg::div255(sum4);
    assign d4_sat = d4[8] ? arp_pkg::ChanMax : d4[arp_pkg::ChanW-1:0];
    assign opaque = (side3.alpha == arp_pkg::ChanMax);
    assign zero_px = (side3.alpha == '0) && !(side3.premul && side3.opa_zero);

    // Result selection by mode.
    always_comb
    begin
        if (zero_px)
        begin
            res_next = '0;
        end
        else if (side3.opa_zero)
        begin
            res_next = (side3.premul || opaque) ? src3_reg : d4[arp_pkg::ChanW-1:0];
        end
        else if (!side3.premul)
        begin
            res_next = opaque ? c1_3_reg : d4[arp_pkg::ChanW-1:0];
        end
        else
        begin
            res_next = opaque ? c1_3_reg : d4_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.en4)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/argb8888_recolor_premultiply_top.sv
// ----------------------------------------------------------------------------
// argb8888_recolor_premultiply_top
// Blends a configured recolour into ARGB8888 pixels at a configured opacity
// and premultiplies the result by the pixel alpha.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload                 Direction
//  -------  -------------------  ----------------------  ---------
//  in       in_valid / in_stall  in_data  (pix_in_t)     input
//  out      out_valid/out_stall  out_data (pix_out_t)    output
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data     input
//
//  One pixel request is taken per clock while in_stall is low; each one
//  passes through the four-stage multiply and divide pipeline to the output.
//  Reset clears the valid bits and sets both configuration registers to zero.
//  A stall holds the output register; stages behind it keep filling bubbles,
//  so in_stall rises only when the output is held and the pipeline is full.
//  Configuration writes are always accepted.
//
`default_nettype none

module argb8888_recolor_premultiply_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire arp_pkg::pix_in_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output arp_pkg::pix_out_t                  out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [arp_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [arp_pkg::CfgDataW-1:0]  cfg_data
);

    logic [arp_pkg::CfgDataW-1:0] recolor;
    logic                         premul;
    logic [arp_pkg::ChanW-1:0]    opa;
    arp_pkg::adv_t                adv;
    arp_pkg::side_t               side2, side3;
    logic [arp_pkg::ChanW-1:0]    alpha_out, red_out, green_out, blue_out;

    assign opa = recolor[31:24];

    // Configuration registers.
    arp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .recolor   (recolor),
        .premul    (premul)
    );

    // Stage control and alpha path.
    arp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .alpha_in  (in_data.in_alpha),
        .opa_zero  (opa == '0),
        .premul    (premul),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .adv       (adv),
        .side2     (side2),
        .side3     (side3),
        .alpha_out (alpha_out)
    );

    // One datapath per colour channel.
    arp_chan u_red (
        .clk    (clk),
        .adv    (adv),
        .src    (in_data.in_red),
        .rc     (recolor[23:16]),
        .opa    (opa),
        .side2  (side2),
        .side3  (side3),
        .result (red_out)
    );

    arp_chan u_green (
        .clk    (clk),
        .adv    (adv),
        .src    (in_data.in_green),
        .rc     (recolor[15:8]),
        .opa    (opa),
        .side2  (side2),
        .side3  (side3),
        .result (green_out)
    );

    arp_chan u_blue (
        .clk    (clk),
        .adv    (adv),
        .src    (in_data.in_blue),
        .rc     (recolor[7:0]),
        .opa    (opa),
        .side2  (side2),
        .side3  (side3),
        .result (blue_out)
    );

    assign out_data = '{out_alpha: alpha_out, out_red: red_out,
                        out_green: green_out, out_blue: blue_out};

endmodule

`default_nettype wire

>>> rtl/core/arp_checker.sv
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks of the recolour pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_stall,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire arp_pkg::pix_out_t    out_data,
    input  wire logic                 cfg_ready
);

    // A held result request stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    // A held result request keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // Back-pressure only comes from a held output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output");

    // With the output free, the input is never held back.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while the output was free");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind argb8888_recolor_premultiply_top arp_checker u_arp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

>>> sim/argb8888_recolor_premultiply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// argb8888_recolor_premultiply_checker
// Watches the pixel, result and configuration channels of the recolour block.
// It keeps its own copy of the two configuration registers, works out every
// result pixel when its request is accepted, and compares each result that
// leaves with the oldest pixel still awaited.
// ----------------------------------------------------------------------------
module argb8888_recolor_premultiply_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  arp_pkg::pix_in_t                       in_data,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  arp_pkg::pix_out_t                      out_data,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [arp_pkg::CfgIdxW-1:0]            cfg_index,
    input  logic [arp_pkg::CfgDataW-1:0]           cfg_data,
    output int                                     mismatches,
    output int                                     pending
);

    localparam int unsigned FullScale   = arp_pkg::ChanMax;
    localparam int          ReportLimit = 10;

    // Shadow copies of the configuration registers.
    logic [arp_pkg::CfgDataW-1:0] recolor_shadow;
    logic                         premul_shadow;

    // Result pixels worked out but not yet seen on the output.
    arp_pkg::pix_out_t blended_q[$];
    arp_pkg::pix_out_t awaited;
    int                errs;

    // One colour channel: recolour blend followed by the alpha premultiply.
    function automatic logic [arp_pkg::ChanW-1:0] blend_chan(
        input logic [arp_pkg::ChanW-1:0] src,
        input logic [arp_pkg::ChanW-1:0] rc,
        input logic [arp_pkg::ChanW-1:0] a,
        input logic [arp_pkg::ChanW-1:0] opa,
        input logic                      premul
    );
        int unsigned s;
        int unsigned r;
        int unsigned al;
        int unsigned o;
        int unsigned mix;
        int unsigned rterm;
        int unsigned c;
        s     = 32'(src);
        r     = 32'(rc);
        al    = 32'(a);
        o     = 32'(opa);
        mix   = FullScale - o;
        rterm = r * o;
        if (o == 0)
        begin
            // No recolour: straight pixels are premultiplied, others pass.
            if (premul || al == FullScale)
                c = s;
            else
                c = (s * al) / FullScale;
        end
        else if (!premul)
        begin
            c = (s * mix + rterm) / FullScale;
            if (al != FullScale)
                c = (c * al) / FullScale;
        end
        else if (al < FullScale)
        begin
            // Premultiplied source: only the recolour term is scaled by alpha.
            c = (s * mix + (rterm / FullScale) * al) / FullScale;
        end
        else
        begin
            c = (s * mix + rterm) / FullScale;
        end
        if (c > FullScale)
            c = FullScale;
        return c[arp_pkg::ChanW-1:0];
    endfunction

    // Whole result pixel for one request under the current settings.
    function automatic arp_pkg::pix_out_t recolor_pixel(input arp_pkg::pix_in_t px);
        arp_pkg::pix_out_t         res;
        logic [arp_pkg::ChanW-1:0] opa;
        opa = recolor_shadow[31:24];
        res = '0;
        // A transparent pixel clears to zero unless it passes untouched.
        if (px.in_alpha != 0 || (premul_shadow && opa == 0))
        begin
            res.out_alpha = px.in_alpha;
            res.out_red   = blend_chan(px.in_red, recolor_shadow[23:16],
                                       px.in_alpha, opa, premul_shadow);
            res.out_green = blend_chan(px.in_green, recolor_shadow[15:8],
                                       px.in_alpha, opa, premul_shadow);
            res.out_blue  = blend_chan(px.in_blue, recolor_shadow[7:0],
                                       px.in_alpha, opa, premul_shadow);
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input arp_pkg::pix_out_t want,
                                 input arp_pkg::pix_out_t got);
        errs++;
        if (errs <= ReportLimit)
            $display("checker: %s at %0t: expected a=%h r=%h g=%h b=%h, got a=%h r=%h g=%h b=%h",
                     what, $realtime, want.out_alpha, want.out_red, want.out_green,
                     want.out_blue, got.out_alpha, got.out_red, got.out_green,
                     got.out_blue);
    endtask

    // Follow the register writes, then the result and pixel requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recolor_shadow = '0;
            premul_shadow  = 1'b0;
            blended_q.delete();
            errs       = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    arp_pkg::CfgIdxRecolor: recolor_shadow = cfg_data;
                    arp_pkg::CfgIdxPremul:  premul_shadow  = cfg_data[0];
                    default:                ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (blended_q.size() == 0)
                begin
                    note_mismatch("result with none awaited", '0, out_data);
                end
                else
                begin
                    awaited = blended_q.pop_front();
                    if (out_data.out_alpha !== awaited.out_alpha
                        || out_data.out_red !== awaited.out_red
                        || out_data.out_green !== awaited.out_green
                        || out_data.out_blue !== awaited.out_blue)
                        note_mismatch("wrong result pixel", awaited, out_data);
                end
            end
            if (in_valid && !in_stall)
                blended_q.push_back(recolor_pixel(in_data));
            mismatches <= errs;
            pending    <= blended_q.size();
        end
    end

endmodule

>>> sim/argb8888_recolor_premultiply_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// argb8888_recolor_premultiply_top_tb
// Drives pixel requests and register writes into the recolour block under
// several pacing phases and leaves prediction and comparison to the checker.
// A directed set covers transparent, opaque and over-range pixels under each
// kind of setting; random pixels follow under a run of random settings.
// ----------------------------------------------------------------------------
module argb8888_recolor_premultiply_top_tb;

    localparam int IdleLimit   = 2000;
    localparam int DrainCycles = 8;
    localparam int NumPhases   = 4;
    localparam int NumSettings = 5;
    localparam int PerSetting  = 25;

    // Indexes beyond the register list; writes to them must be ignored.
    localparam logic [arp_pkg::CfgIdxW-1:0] CfgIdxSpare = arp_pkg::CfgIdxPremul + 1'b1;
    localparam logic [arp_pkg::CfgIdxW-1:0] CfgIdxTop   = '1;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    arp_pkg::pix_in_t             in_data;
    logic                         out_valid;
    logic                         out_stall;
    arp_pkg::pix_out_t            out_data;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [arp_pkg::CfgIdxW-1:0]  cfg_index;
    logic [arp_pkg::CfgDataW-1:0] cfg_data;

    int mismatches;
    int pending;
    int send_idle_pct;
    int stall_pct;
    int pixels_sent;
    int settings_used;
    int quiet_cycles;

    argb8888_recolor_premultiply_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    argb8888_recolor_premultiply_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure at the rate of the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IdleLimit)
        begin
            $display("watchdog: no traffic for %0d cycles", IdleLimit);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one pixel request, with random idle cycles ahead of it.
    task automatic send_pixel(input arp_pkg::pix_in_t px);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    task automatic send_argb(input logic [31:0] argb);
        send_pixel(arp_pkg::pix_in_t'(argb));
    endtask

    // Hold a register write until the block takes it; valid stays high.
    task automatic write_reg(input logic [arp_pkg::CfgIdxW-1:0] idx,
                             input logic [arp_pkg::CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Stop sending, wait for every awaited result, then for the DrainCycles drain.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Load both registers in random order, optionally with a stray index.
    task automatic load_settings(input logic [31:0] recolor,
                                 input logic [31:0] premul_word, input bit stray);
        if (stray)
            write_reg($urandom_range(0, 1) ? CfgIdxSpare : CfgIdxTop, $urandom());
        if ($urandom_range(0, 1))
        begin
            write_reg(arp_pkg::CfgIdxRecolor, recolor);
            write_reg(arp_pkg::CfgIdxPremul, premul_word);
        end
        else
        begin
            write_reg(arp_pkg::CfgIdxPremul, premul_word);
            write_reg(arp_pkg::CfgIdxRecolor, recolor);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random pixel: some transparent, some opaque; premultiplied sources
    // mostly keep colour at or below alpha, the rest may go above it.
    function automatic arp_pkg::pix_in_t random_pixel(input logic premul);
        arp_pkg::pix_in_t px;
        int               pick;
        pick = $urandom_range(0, 9);
        px   = arp_pkg::pix_in_t'($urandom());
        if (pick == 0)
            px.in_alpha = '0;
        else if (pick <= 2)
            px.in_alpha = arp_pkg::ChanMax;
        if (premul && $urandom_range(0, 3) != 0)
        begin
            px.in_red   = 8'($urandom_range(0, px.in_alpha));
            px.in_green = 8'($urandom_range(0, px.in_alpha));
            px.in_blue  = 8'($urandom_range(0, px.in_alpha));
        end
        return px;
    endfunction

    initial
    begin : stimulus
        logic [arp_pkg::ChanW-1:0] opa;
        logic [31:0]               recolor;
        logic                      premul;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        pixels_sent   = 0;
        settings_used = 0;
        quiet_cycles  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: straight source, no recolour.
        send_argb(32'h00FF_FFFF);
        send_argb(32'hFF12_3456);
        send_argb(32'h80FF_007F);
        send_argb(32'h01FF_FFFF);
        send_argb(32'hFF00_0000);
        send_argb(32'hFFFF_FFFF);
        settle();

        // Full-opacity recolour on a straight source; wide write of the flag.
        load_settings(32'hFFFF_0080, 32'hFFFF_FFFE, 1'b0);
        send_argb(32'h0012_3456);
        send_argb(32'hFF00_FF55);
        send_argb(32'h7FFF_FFFF);
        settle();

        // Half-opacity recolour on a premultiplied source, stray index first.
        write_reg(CfgIdxTop, 32'hFFFF_FFFF);
        load_settings(32'h8040_C0FF, 32'h1234_5671, 1'b0);
        send_argb(32'h00FF_FFFF);
        send_argb(32'h10FF_FFFF);
        send_argb(32'hFFFF_FFFF);
        send_argb(32'hFE00_0000);
        settle();

        // Premultiplied source with no recolour: pixels pass untouched.
        load_settings(32'h00FF_FFFF, 32'h0000_0001, 1'b1);
        send_argb(32'h00FF_FFFF);
        send_argb(32'h40FF_8001);
        send_argb(32'hFFFF_FFFF);
        settle();

        // Random part: each pacing phase runs through several settings.
        for (int phase = 0; phase < NumPhases; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            for (int k = 0; k < NumSettings; k++)
            begin
                premul  = 1'((phase + k) % 2);
                recolor = $urandom();
                case (k)
                    0: opa = '0;
                    1: opa = arp_pkg::ChanMax;
                    2: opa = 8'd1;
                    default: opa = 8'($urandom_range(0, 255));
                endcase
                if (k == 1)
                    recolor[23:0] = premul ? '1 : '0;
                recolor[31:24] = opa;
                load_settings(recolor, {31'($urandom_range(0, 32'h7FFF_FFFF)), premul},
                              $urandom_range(0, 2) == 0);
                for (int n = 0; n < PerSetting; n++)
                    send_pixel(random_pixel(premul));
                settle();
            end
        end

        $display("summary: %0d pixels under %0d register settings,", pixels_sent,
                 settings_used);
        $display("summary: paced with no gaps, sender gaps, receiver stalls and both");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
